/* rtl/core/bltmh_pkg.sv */
// ============================================================================
// bltmh_pkg
// Shared widths, constants and thresholds of the battery level monitor.
// ============================================================================
package bltmh_pkg;

    // Burst length and field widths
    localparam int SAMPLES  = 10;
    localparam int SAMPLE_W = 10;
    localparam int FS_W     = 12;
    localparam int MV_W     = 12;
    localparam int LEVEL_W  = 2;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    // Accumulator widths follow from the burst length
    localparam int IDX_W  = $clog2(SAMPLES);
    localparam int SUM_W  = $clog2(SAMPLES * SAMPLE_MAX + 1);
    localparam int TRIM_W = $clog2((SAMPLES - 2) * SAMPLE_MAX + 1);

    // full_scale * trimmed sum, then divided by (SAMPLES-2)*1024 through an
    // exact reciprocal: floor(p/d) = (p * RECIP) >> REC_SHIFT for p < 2^PROD_W
    localparam int PROD_W    = FS_W + TRIM_W;
    localparam int DIVISOR   = (SAMPLES - 2) * 1024;
    localparam int DIV_LOG   = $clog2(DIVISOR);
    localparam int REC_SHIFT = PROD_W + DIV_LOG;
    localparam int RECIP_W   = PROD_W + 1;
    localparam logic [63:0] RECIP =
        ((64'd1 << REC_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int SCALED_W  = PROD_W + RECIP_W;

    localparam logic [MV_W-1:0] MV_MAX = {MV_W{1'b1}};

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_FULL_SCALE = 1'b0;
    localparam logic [FS_W-1:0] FS_RESET = 12'd3600;

    // Battery levels
    localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MID   = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 2'd3;

    // Plain thresholds for the first burst
    localparam logic [MV_W-1:0] TH_FULL = 12'd2900;
    localparam logic [MV_W-1:0] TH_MID  = 12'd2800;
    localparam logic [MV_W-1:0] TH_LOW  = 12'd2700;

    // Hysteresis band edges for later bursts
    localparam logic [MV_W-1:0] HY_FULL_LO  = 12'd2920;
    localparam logic [MV_W-1:0] HY_MID_HI   = 12'd2880;
    localparam logic [MV_W-1:0] HY_MID_LO   = 12'd2820;
    localparam logic [MV_W-1:0] HY_LOW_HI   = 12'd2780;
    localparam logic [MV_W-1:0] HY_LOW_LO   = 12'd2720;
    localparam logic [MV_W-1:0] HY_EMPTY_HI = 12'd2680;

endpackage

/* rtl/core/battery_level_trimmed_mean_hysteresis.sv */
// ============================================================================
// battery_level_trimmed_mean_hysteresis
// Trimmed mean of a burst of supply samples, scaled to millivolts, then a
// battery level classifier with hysteresis.
// ============================================================================
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  input   | in        | in_valid / in_stall    | sample[9:0]
//  output  | out       | out_valid / out_stall  | voltage_mv[11:0], level[1:0],
//          |           |                        | level_updated
//  config  | in        | APB psel/penable/...   | full_scale_mv at address 0
//
//  One sample item is accepted per cycle while in_stall is low; the running
//  sum, minimum and maximum update in that cycle. The last sample of a burst
//  launches a four-stage pipe (trim, full-scale multiply, reciprocal multiply,
//  classify). The trim register loads at the accepting edge; the item then
//  moves through the product, scaled and output registers in turn.
//  Reset clears the burst, the held level and the pipe valid bits at once,
//  and loads full_scale_mv with 3600.
//  A stall on the output holds the pipe; in_stall rises only when the trim
//  stage holds an item that cannot move on.
//
module battery_level_trimmed_mean_hysteresis
    import bltmh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // sample channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,

    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [MV_W-1:0]     voltage_mv,
    output logic [LEVEL_W-1:0]  level,
    output logic                level_updated,

    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [FS_W-1:0] full_scale_reg;
    logic            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_FULL_SCALE);
    assign prdata    = (paddr[ADDR_W-1] == REG_FULL_SCALE)
                     ? {{(DATA_W-FS_W){1'b0}}, full_scale_reg}
                     : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= FS_RESET;
        end
        else if (cfg_write)
        begin
            // drop bits above the register width
            full_scale_reg <= pwdata[FS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipe flow control
    // ------------------------------------------------------------------
    logic trim_valid_reg,   trim_valid_next;
    logic prod_valid_reg,   prod_valid_next;
    logic scaled_valid_reg, scaled_valid_next;
    logic out_valid_reg,    out_valid_next;

    logic out_free, scaled_free, prod_free, trim_free;
    logic accept, last_sample, trim_load;

    // a stage is free when it is empty or its item moves on this cycle
    assign out_free    = !out_valid_reg || !out_stall;
    assign scaled_free = !scaled_valid_reg || out_free;
    assign prod_free   = !prod_valid_reg || scaled_free;
    assign trim_free   = !trim_valid_reg || prod_free;

    assign in_stall  = !trim_free;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Burst accumulator
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]    index_reg, index_next;
    logic [SUM_W-1:0]    sum_reg,   sum_next;
    logic [SAMPLE_W-1:0] min_reg,   min_next;
    logic [SAMPLE_W-1:0] max_reg,   max_next;
    logic [SUM_W-1:0]    sum_acc;
    logic [SAMPLE_W-1:0] min_acc, max_acc;
    logic [SUM_W-1:0]    trim_full;
    logic [TRIM_W-1:0]   trim_reg;

    assign last_sample = (index_reg == IDX_W'(SAMPLES - 1));
    assign trim_load   = accept && last_sample;

    always_comb
    begin
        sum_acc   = sum_reg + SUM_W'(sample);
        min_acc   = (sample < min_reg) ? sample : min_reg;
        max_acc   = (sample > max_reg) ? sample : max_reg;
        // drop the extremes of the burst
        trim_full = sum_acc - SUM_W'(min_acc) - SUM_W'(max_acc);

        index_next = index_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (accept)
        begin
            if (last_sample)
            begin
                // start a new burst
                index_next = '0;
                sum_next   = '0;
                min_next   = SAMPLE_W'(SAMPLE_MAX);
                max_next   = '0;
            end
            else
            begin
                index_next = index_reg + IDX_W'(1);
                sum_next   = sum_acc;
                min_next   = min_acc;
                max_next   = max_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= SAMPLE_W'(SAMPLE_MAX);
            max_reg   <= '0;
        end
        else
        begin
            index_reg <= index_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    // ------------------------------------------------------------------
    // Scaling pipe: trim -> full-scale product -> reciprocal product
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]   prod_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic                prod_load, scaled_load;

    assign prod_load   = trim_valid_reg && prod_free;
    assign scaled_load = prod_valid_reg && scaled_free;

    always_comb
    begin
        trim_valid_next   = trim_load ? 1'b1 : (trim_valid_reg && !prod_free);
        prod_valid_next   = prod_load ? 1'b1 : (prod_valid_reg && !scaled_free);
        scaled_valid_next = scaled_load ? 1'b1 : (scaled_valid_reg && !out_free);
        out_valid_next    = out_free ? scaled_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_valid_reg   <= 1'b0;
            prod_valid_reg   <= 1'b0;
            scaled_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            trim_valid_reg   <= trim_valid_next;
            prod_valid_reg   <= prod_valid_next;
            scaled_valid_reg <= scaled_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (trim_load)
        begin
            trim_reg <= trim_full[TRIM_W-1:0];
        end
        if (prod_load)
        begin
            prod_reg <= PROD_W'(full_scale_reg) * PROD_W'(trim_reg);
        end
        if (scaled_load)
        begin
            // divide by (SAMPLES-2)*1024 as a multiply by its reciprocal
            scaled_reg <= SCALED_W'(prod_reg) * SCALED_W'(RECIP[RECIP_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Millivolts and level classification
    // ------------------------------------------------------------------
    logic [SCALED_W-REC_SHIFT-1:0] quot;
    logic [MV_W-1:0]               mv;
    logic [LEVEL_W-1:0]            level_calc;
    logic                          hit;
    logic                          first_done_reg;
    logic [LEVEL_W-1:0]            held_level_reg;

    assign quot = scaled_reg[SCALED_W-1:REC_SHIFT];

    always_comb
    begin
        // saturate at full range
        mv = (quot > (SCALED_W-REC_SHIFT)'(MV_MAX)) ? MV_MAX : quot[MV_W-1:0];

        hit        = 1'b1;
        level_calc = held_level_reg;
        if (!first_done_reg)
        begin
            if (mv >= TH_FULL)
                level_calc = LEVEL_FULL;
            else if (mv >= TH_MID)
                level_calc = LEVEL_MID;
            else if (mv >= TH_LOW)
                level_calc = LEVEL_LOW;
            else
                level_calc = LEVEL_EMPTY;
        end
        else
        begin
            if (mv > HY_FULL_LO)
                level_calc = LEVEL_FULL;
            else if (mv > HY_MID_LO && mv < HY_MID_HI)
                level_calc = LEVEL_MID;
            else if (mv > HY_LOW_LO && mv < HY_LOW_HI)
                level_calc = LEVEL_LOW;
            else if (mv < HY_EMPTY_HI)
                level_calc = LEVEL_EMPTY;
            else
                hit = 1'b0;   // dead band: hold the previous level
        end
    end

    // advance the held level as the result item enters the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_done_reg <= 1'b0;
            held_level_reg <= LEVEL_EMPTY;
        end
        else if (scaled_valid_reg && out_free)
        begin
            first_done_reg <= 1'b1;
            held_level_reg <= level_calc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scaled_valid_reg && out_free)
        begin
            voltage_mv    <= mv;
            level         <= level_calc;
            level_updated <= hit;
        end
    end

endmodule

/* bench/battery_level_trimmed_mean_hysteresis_tb.sv */
// ============================================================================
// battery_level_trimmed_mean_hysteresis_tb
// Streams bursts of supply samples into the battery level monitor. A local
// model tracks the burst sum, minimum and maximum, the scaled trimmed mean and
// the held battery level, and each result item is checked against it.
// ============================================================================
module battery_level_trimmed_mean_hysteresis_tb;
    import bltmh_pkg::*;

    // Run shape
    localparam int SAMPLE_ITEMS   = 950;   // stop sending after this many samples
    localparam int SETTLE_CYCLES  = 8;     // four-stage result pipe plus margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving
    localparam int IDLE_PCT       = 26;

    // Register map: index 0 is full_scale_mv, index 1 is unused
    localparam logic [ADDR_W-1:0] ADDR_FULL_SCALE = ADDR_W'(4 * int'(REG_FULL_SCALE));
    localparam logic [ADDR_W-1:0] ADDR_SPARE      = ADDR_W'(4);

    typedef struct packed {
        logic [MV_W-1:0]    voltage_mv;
        logic [LEVEL_W-1:0] level;
        logic               level_updated;
    } reading_t;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample        = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [MV_W-1:0]     voltage_mv;
    logic [LEVEL_W-1:0]  level;
    logic                level_updated;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    battery_level_trimmed_mean_hysteresis dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .voltage_mv    (voltage_mv),
        .level         (level),
        .level_updated (level_updated),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------------
    int          idle_pct     = IDLE_PCT;
    int          fail_count   = 0;
    int          samples_sent = 0;
    int          quiet_cycles = 0;

    // Local copy of the monitor: configuration, burst accumulators, level
    logic [FS_W-1:0]    full_scale;
    int unsigned        burst_sum;
    int unsigned        burst_lo;
    int unsigned        burst_hi;
    int                 burst_count;
    bit                 seen_first_burst;
    logic [LEVEL_W-1:0] held_lvl;

    // Readings still owed by the block, oldest first
    reading_t pending_readings[$];

    function automatic void clear_burst();
        burst_sum   = 0;
        burst_lo    = SAMPLE_MAX;
        burst_hi    = 0;
        burst_count = 0;
    endfunction

    function automatic void reset_monitor_model();
        full_scale       = FS_RESET;
        seen_first_burst = 1'b0;
        held_lvl         = LEVEL_EMPTY;
        clear_burst();
    endfunction

    // Fold one accepted sample into the burst; at the burst end, scale the
    // trimmed sum, classify the level and queue the reading.
    function automatic void take_sample(input logic [SAMPLE_W-1:0] s);
        longint unsigned trimmed;
        longint unsigned mv;
        logic [MV_W-1:0] v;
        reading_t        r;
        bit              hit;
        burst_sum += s;
        if (s < burst_lo)
            burst_lo = s;
        if (s > burst_hi)
            burst_hi = s;
        burst_count++;
        if (burst_count < SAMPLES)
            return;

        trimmed = burst_sum - burst_lo - burst_hi;
        mv = (longint'(full_scale) * trimmed) / (SAMPLES - 2) / 1024;
        if (mv > MV_MAX)
            mv = MV_MAX;
        v   = MV_W'(mv);
        hit = 1'b1;

        if (!seen_first_burst)
        begin
            // first burst: plain thresholds, always an update
            if (v >= TH_FULL)
                held_lvl = LEVEL_FULL;
            else if (v >= TH_MID)
                held_lvl = LEVEL_MID;
            else if (v >= TH_LOW)
                held_lvl = LEVEL_LOW;
            else
                held_lvl = LEVEL_EMPTY;
        end
        else
        begin
            // later bursts: open bands, hold the level in the gaps
            if (v > HY_FULL_LO)
                held_lvl = LEVEL_FULL;
            else if (v > HY_MID_LO && v < HY_MID_HI)
                held_lvl = LEVEL_MID;
            else if (v > HY_LOW_LO && v < HY_LOW_HI)
                held_lvl = LEVEL_LOW;
            else if (v < HY_EMPTY_HI)
                held_lvl = LEVEL_EMPTY;
            else
                hit = 1'b0;
        end
        seen_first_burst = 1'b1;

        r.voltage_mv    = v;
        r.level         = held_lvl;
        r.level_updated = hit;
        pending_readings.push_back(r);
        clear_burst();
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall at random, check each item as it is taken. Outputs
    // and out_stall only change at the rising edge, so the falling edge sees
    // exactly what the next rising edge will accept.
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    always @(negedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected result item: voltage_mv %0d level %0d level_updated %0d",
                       voltage_mv, level, level_updated);
                fail_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (voltage_mv !== want.voltage_mv)
                begin
                    $error("voltage_mv: expected %0d, actual %0d",
                           want.voltage_mv, voltage_mv);
                    fail_count++;
                end
                if (level !== want.level)
                begin
                    $error("level: expected %0d, actual %0d", want.level, level);
                    fail_count++;
                end
                if (level_updated !== want.level_updated)
                begin
                    $error("level_updated: expected %0d, actual %0d",
                           want.level_updated, level_updated);
                    fail_count++;
                end
            end
        end
    end

    // Give up when no item moves on either channel for too long
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL battery_level_trimmed_mean_hysteresis");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shared drivers. Every task starts and ends just after a rising edge.
    // ------------------------------------------------------------------------

    // Offer one sample item, idling first at random; return after the edge
    // that accepts it, with valid still high for a possible next item.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        // stall is settled by the falling edge; hold until it is low
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        take_sample(s);
        samples_sent++;
    endtask

    // Drop valid, drain every owed reading, then let the pipe go empty
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] a, output logic [DATA_W-1:0] d);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        paddr  <= a;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        d = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Change full scale while idle; fill the upper bits with junk, which the
    // register must drop.
    task automatic write_full_scale(input logic [FS_W-1:0] value);
        logic [DATA_W-1:0] word;
        settle_block();
        word = $urandom();
        word[FS_W-1:0] = value;
        apb_write(ADDR_FULL_SCALE, word);
        full_scale = value;
    endtask

    task automatic check_full_scale_readback();
        logic [DATA_W-1:0] got;
        apb_read(ADDR_FULL_SCALE, got);
        if (got[FS_W-1:0] !== full_scale)
        begin
            $error("full_scale_mv: expected %0d, actual %0d", full_scale, got[FS_W-1:0]);
            fail_count++;
        end
    endtask

    // One well-formed burst whose trimmed mean lands on target_mv: eight
    // middle samples carry the trimmed sum, one sample at or below them and
    // one at or above them are the ones that get dropped. Shuffle the order.
    task automatic send_burst_at(input int unsigned target_mv);
        logic [SAMPLE_W-1:0] vals[SAMPLES];
        logic [SAMPLE_W-1:0] swap;
        int unsigned         t;
        int unsigned         base;
        int unsigned         rem;
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         d;
        int                  j;
        // finish any broken burst first so this one starts aligned
        while (burst_count != 0)
            send_sample($urandom_range(SAMPLE_MAX));

        t = (target_mv * 8192 + full_scale - 1) / full_scale;
        if (t > (SAMPLES - 2) * SAMPLE_MAX)
            t = (SAMPLES - 2) * SAMPLE_MAX;
        base = t / (SAMPLES - 2);
        rem  = t % (SAMPLES - 2);
        lo   = $urandom_range(base);
        hi   = $urandom_range(SAMPLE_MAX, base + (rem != 0));
        for (int i = 0; i < SAMPLES - 2; i++)
            vals[i] = SAMPLE_W'(base + (i < rem));
        // spread the middle a little; the sum and the extremes stay put
        for (int i = 0; i + 1 < SAMPLES - 2; i += 2)
        begin
            d = $urandom_range(4);
            if (vals[i] >= lo + d && vals[i+1] + d <= hi)
            begin
                vals[i]   = vals[i] - SAMPLE_W'(d);
                vals[i+1] = vals[i+1] + SAMPLE_W'(d);
            end
        end
        vals[SAMPLES-2] = SAMPLE_W'(lo);
        vals[SAMPLES-1] = SAMPLE_W'(hi);
        for (int i = SAMPLES - 1; i > 0; i--)
        begin
            j       = $urandom_range(i);
            swap    = vals[i];
            vals[i] = vals[j];
            vals[j] = swap;
        end
        foreach (vals[i])
            send_sample(vals[i]);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset value, a write to the unused index, junk in the upper bits
    task automatic test_register_access();
        check_full_scale_readback();
        apb_write(ADDR_SPARE, $urandom());
        check_full_scale_readback();
        write_full_scale(FS_RESET);
        check_full_scale_readback();
    endtask

    // First burst uses the plain thresholds: 8 x 825 trims to 2900 mV at the
    // reset full scale, right on the top threshold. Both sample extremes are
    // the dropped ones.
    task automatic test_first_burst();
        send_sample('0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        repeat (SAMPLES - 2)
            send_sample(SAMPLE_W'(825));
    endtask

    // Largest full scale with every sample at full code: the highest voltage
    task automatic test_sample_extremes();
        write_full_scale('1);
        check_full_scale_readback();
        repeat (SAMPLES)
            send_sample(SAMPLE_W'(SAMPLE_MAX));
    endtask

    // Phases of bursts at one full scale each. Most bursts aim near a band
    // edge so the hysteresis gaps get hit from every side; the rest are
    // random bursts and broken partial bursts.
    task automatic test_level_bands();
        int          phase;
        int unsigned pick;
        int unsigned tgt;
        logic [FS_W-1:0] fs;
        phase = 0;
        while (samples_sent < SAMPLE_ITEMS)
        begin
            // keep the first two phases free of idling on both sides
            idle_pct = (phase < 2) ? 0 : IDLE_PCT;
            case (phase)
                2:       fs = FS_W'(1);
                3:       fs = '1;
                default: fs = ($urandom_range(99) < 70) ? FS_W'($urandom_range(4095, 2930))
                                                         : FS_W'($urandom_range(4095, 1));
            endcase
            write_full_scale(fs);
            if (phase % 4 == 0)
                check_full_scale_readback();

            repeat ($urandom_range(12, 4))
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    case ($urandom_range(9))
                        0:       tgt = HY_EMPTY_HI;
                        1:       tgt = HY_LOW_LO;
                        2:       tgt = HY_LOW_HI;
                        3:       tgt = HY_MID_LO;
                        4:       tgt = HY_MID_HI;
                        5:       tgt = HY_FULL_LO;
                        6:       tgt = TH_LOW;
                        7:       tgt = TH_MID;
                        8:       tgt = TH_FULL;
                        default: tgt = $urandom_range(3000, 2600);
                    endcase
                    send_burst_at(tgt + $urandom_range(6) - 3);
                end
                else if (pick < 90)
                begin
                    repeat (SAMPLES)
                        send_sample($urandom_range(SAMPLE_MAX));
                end
                else
                begin
                    repeat ($urandom_range(SAMPLES - 1, 1))
                        send_sample($urandom_range(SAMPLE_MAX));
                end
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_monitor_model();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_first_burst();
        test_sample_extremes();
        test_level_bands();

        // drain the last readings and give stray items time to show up
        settle_block();
        if (fail_count == 0)
            $display("PASS battery_level_trimmed_mean_hysteresis");
        else
            $display("FAIL battery_level_trimmed_mean_hysteresis");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bltmh_pkg.sv
rtl/core/battery_level_trimmed_mean_hysteresis.sv
bench/battery_level_trimmed_mean_hysteresis_tb.sv
